// ===== design/plbp_pkg.sv =====
// Shared constants, codes and control types of the perceptron branch predictor.
`default_nettype none
package plbp_pkg;

  localparam int DEF_TABLE_ENTRIES  = 256;
  localparam int DEF_HISTORY_LENGTH = 62;
  localparam int DEF_WEIGHT_BITS    = 8;

  localparam int PC_W     = 48;
  localparam int IDX_LSB  = 4;
  localparam int PCS_W    = PC_W - IDX_LSB;
  localparam int THR_W    = 13;
  localparam int SUM_W    = 14;
  localparam int GROUP    = 8;

  localparam logic [THR_W-1:0] THR_RESET = 13'd133;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 14'sd8191;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -14'sd8192;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic mod_step;
    logic read_row;
    logic calc_partial;
    logic do_update;
    logic do_final;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic is_update;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== design/plbp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module plbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/plbp_ctrl.sv =====
// Sequencing state machine of the perceptron branch predictor.
`default_nettype none
module plbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire plbp_pkg::ctrl_sts_t sts,
  output plbp_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_INDEX, ST_READ, ST_FETCH, ST_SUM, ST_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.clear_step   = (state == ST_CLEAR);
    cmd.load_in      = (state == ST_IDLE) && in_valid;
    cmd.mod_step     = (state == ST_INDEX);
    cmd.read_row     = (state == ST_READ);
    cmd.calc_partial = (state == ST_FETCH) && !sts.is_update;
    cmd.do_update    = (state == ST_FETCH) && sts.is_update;
    cmd.do_final     = (state == ST_SUM);
    cmd.load_out     = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (sts.mod_done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          state <= sts.is_update ? ST_DONE : ST_SUM;
        end
        ST_SUM: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/plbp_dp.sv =====
// Datapath: entry index, row store, perceptron sum and training logic.
`default_nettype none
module plbp_dp #(
  parameter int TABLE_ENTRIES  = plbp_pkg::DEF_TABLE_ENTRIES,
  parameter int HISTORY_LENGTH = plbp_pkg::DEF_HISTORY_LENGTH,
  parameter int WEIGHT_BITS    = plbp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire plbp_pkg::ctrl_cmd_t         cmd,
  output plbp_pkg::ctrl_sts_t              sts,
  input  wire logic                        in_command,
  input  wire logic [plbp_pkg::PC_W-1:0]   in_pc,
  input  wire logic                        in_predicted_taken,
  input  wire logic                        in_actual_taken,
  input  wire logic                        cfg_wr_en,
  input  wire logic [plbp_pkg::THR_W-1:0]  cfg_wr_data,
  output logic                             out_predict_taken,
  output logic [plbp_pkg::SUM_W-1:0]       out_perceptron_sum,
  output logic                             out_trained
);

  localparam int H      = HISTORY_LENGTH;
  localparam int W      = WEIGHT_BITS;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(H + 1);
  localparam int RW     = H * W + W + H + FILL_W;
  localparam int NG     = (H + plbp_pkg::GROUP - 1) / plbp_pkg::GROUP;
  localparam int PW     = W + 4;
  localparam int SW0    = W + 8;
  localparam int SW     = (SW0 > plbp_pkg::SUM_W + 1) ? SW0 : plbp_pkg::SUM_W + 1;
  localparam bit POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int DIG_W  = 4;
  localparam int DIGITS = plbp_pkg::PCS_W / DIG_W;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Latched item and configuration
  logic                                    is_update;
  logic                                    pred_q;
  logic                                    act_q;
  logic [plbp_pkg::THR_W-1:0]              threshold;
  logic signed [plbp_pkg::SUM_W-1:0]       last_sum;
  logic [IDX_W-1:0]                        idx;
  logic [IDX_W-1:0]                        clr_cnt;

  // Result holding registers
  logic                                    res_taken;
  logic signed [plbp_pkg::SUM_W-1:0]       res_sum;
  logic                                    res_trained;

  logic [RW-1:0] rd_row;
  logic [RW-1:0] new_row;
  logic          ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;

  // Row fields
  logic signed [W-1:0] rd_bias;
  logic [H-1:0]        rd_hist;
  logic [FILL_W-1:0]   rd_fill;
  logic [H-1:0]        filled;

  assign rd_bias = rd_row[H*W +: W];
  assign rd_hist = rd_row[H*W+W +: H];
  assign rd_fill = rd_row[H*W+W+H +: FILL_W];

  // Entry index: part-select for a power-of-two table, else a remainder taken
  // four bits a cycle by compare and subtract
  generate
    if (POW2) begin : g_idx_pow2
      always_ff @(posedge clk) begin
        if (cmd.load_in) begin
          idx <= in_pc[plbp_pkg::IDX_LSB +: IDX_W];
        end
      end
      assign sts.mod_done = 1'b1;
    end else begin : g_idx_mod
      logic [plbp_pkg::PCS_W-1:0] pcs;
      logic [CNT_W-1:0]           mod_cnt;
      logic [IDX_W+DIG_W-1:0]     rem_next;

      always_comb begin
        rem_next = {idx, pcs[plbp_pkg::PCS_W-1 -: DIG_W]};
        for (int s = DIG_W - 1; s >= 0; s--) begin
          if (rem_next >= (IDX_W+DIG_W)'(TABLE_ENTRIES << s)) begin
            rem_next = rem_next - (IDX_W+DIG_W)'(TABLE_ENTRIES << s);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.load_in) begin
          pcs     <= in_pc[plbp_pkg::PC_W-1:plbp_pkg::IDX_LSB];
          mod_cnt <= '0;
          idx     <= '0;
        end else if (cmd.mod_step && !sts.mod_done) begin
          pcs     <= pcs << DIG_W;
          mod_cnt <= mod_cnt + 1'b1;
          idx     <= rem_next[IDX_W-1:0];
        end
      end
      assign sts.mod_done = (mod_cnt == CNT_W'(DIGITS));
    end
  endgenerate

  assign sts.is_update  = is_update;
  assign sts.clear_last = (clr_cnt == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_update <= (in_command == plbp_pkg::CMD_UPDATE);
      pred_q    <= in_predicted_taken;
      act_q     <= in_actual_taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Row store: weights, bias, history bits and fill count per entry
  assign ram_we    = cmd.clear_step || cmd.do_update;
  assign ram_waddr = cmd.clear_step ? clr_cnt : idx;
  assign ram_wdata = cmd.clear_step ? '0 : new_row;

  plbp_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_row),
    .raddr (idx),
    .rdata (rd_row)
  );

  // Per-slot terms and training
  logic signed [PW-1:0] term [NG*plbp_pkg::GROUP];
  logic signed [PW-1:0] partial [NG];
  logic signed [PW-1:0] partial_next [NG];
  logic do_train;
  logic [plbp_pkg::SUM_W-1:0] mag;
  logic signed [W-1:0] bias_new;

  genvar gi;
  generate
    for (gi = 0; gi < NG * plbp_pkg::GROUP; gi++) begin : g_slot
      if (gi < H) begin : g_live
        logic signed [W-1:0] w;
        assign w           = rd_row[gi*W +: W];
        assign filled[gi]  = (rd_fill >= FILL_W'(H - gi));
        assign term[gi]    = !filled[gi] ? '0
                           : (rd_hist[gi] ? PW'(w) : -PW'(w));
        // step towards the outcome times the slot value
        assign new_row[gi*W +: W] =
            (!do_train || !filled[gi]) ? w
          : ((act_q == rd_hist[gi]) ? ((w == WMAX) ? w : w + 1'b1)
                                    : ((w == WMIN) ? w : w - 1'b1));
      end else begin : g_pad
        assign term[gi] = '0;
      end
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      partial_next[g] = '0;
      for (int j = 0; j < plbp_pkg::GROUP; j++) begin
        partial_next[g] = partial_next[g] + term[g*plbp_pkg::GROUP + j];
      end
    end
  end

  assign mag      = last_sum[plbp_pkg::SUM_W-1] ? -last_sum : last_sum;
  assign do_train = (pred_q != act_q) || (mag <= {1'b0, threshold});
  assign bias_new = !do_train ? rd_bias
                  : (act_q ? ((rd_bias == WMAX) ? rd_bias : rd_bias + 1'b1)
                           : ((rd_bias == WMIN) ? rd_bias : rd_bias - 1'b1));

  assign new_row[H*W +: W]             = bias_new;
  assign new_row[H*W+W +: H]           = H'({act_q, rd_hist} >> 1);
  assign new_row[H*W+W+H +: FILL_W]    = (rd_fill == FILL_W'(H)) ? rd_fill
                                                                 : rd_fill + 1'b1;

  // Final sum over the group partials plus bias, then saturate
  logic signed [W-1:0]  bias_q;
  logic signed [SW-1:0] total;
  logic signed [plbp_pkg::SUM_W-1:0] sat_sum;

  always_comb begin
    total = SW'(bias_q);
    for (int g = 0; g < NG; g++) begin
      total = total + SW'(partial[g]);
    end
    if (total > SW'(plbp_pkg::SUM_MAX)) begin
      sat_sum = plbp_pkg::SUM_MAX;
    end else if (total < SW'(plbp_pkg::SUM_MIN)) begin
      sat_sum = plbp_pkg::SUM_MIN;
    end else begin
      sat_sum = total[plbp_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_partial) begin
      partial <= partial_next;
      bias_q  <= rd_bias;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= plbp_pkg::THR_RESET;
      last_sum  <= '0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (cmd.do_final) begin
        last_sum <= sat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_final) begin
      res_taken   <= !sat_sum[plbp_pkg::SUM_W-1] && (sat_sum != '0);
      res_sum     <= sat_sum;
      res_trained <= 1'b0;
    end else if (cmd.do_update) begin
      res_taken   <= 1'b0;
      res_sum     <= last_sum;
      res_trained <= do_train;
    end
    if (cmd.load_out) begin
      out_predict_taken  <= res_taken;
      out_perceptron_sum <= res_sum;
      out_trained        <= res_trained;
    end
  end

endmodule
`default_nettype wire

// ===== design/perceptron_local_branch_predictor_unit.sv =====
// Top level of the perceptron branch predictor with local history.
`default_nettype none
// Perceptron branch predictor, one perceptron and one local history per table
// entry, entry chosen by pc bits 4 and up modulo TABLE_ENTRIES. A predict word
// returns bias plus the weighted history sum (saturated to 14 bits) and keeps it;
// an update word trains the entry when the given prediction was wrong or the
// kept sum is small, then shifts the outcome into the history. Each entry is one
// wide row of a single-port-read RAM, so one word is handled at a time: a
// predict word passes through index, read, registered group sums of eight
// slots, final add and hand-off, and an update word through index, read,
// training write and hand-off; the index step takes a remainder four pc bits
// a cycle when TABLE_ENTRIES is not a power of two. A result not yet taken
// holds the block in hand-off, and the next word is taken once the block is
// back in idle. After reset the row RAM is cleared entry by entry, during
// which no word is accepted; threshold writes are taken at any time. A
// finished result waits in an output register.
module perceptron_local_branch_predictor_unit #(
  parameter int TABLE_ENTRIES  = plbp_pkg::DEF_TABLE_ENTRIES,
  parameter int HISTORY_LENGTH = plbp_pkg::DEF_HISTORY_LENGTH,
  parameter int WEIGHT_BITS    = plbp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // pc[47:0], predicted_taken, actual_taken, zero pad
  input  wire logic        s_tuser,   // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // predict_taken, perceptron_sum[13:0], trained
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data // train_threshold
);

  plbp_pkg::ctrl_cmd_t cmd;
  plbp_pkg::ctrl_sts_t sts;

  logic                          out_predict_taken;
  logic [plbp_pkg::SUM_W-1:0]    out_perceptron_sum;
  logic                          out_trained;

  // Sequence each word through index, read, sum or train, and hand-off
  plbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Unpack the input word and hold the result fields
  plbp_dp #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .HISTORY_LENGTH (HISTORY_LENGTH),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (s_tuser),
    .in_pc              (s_tdata[47:0]),
    .in_predicted_taken (s_tdata[48]),
    .in_actual_taken    (s_tdata[49]),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_predict_taken  (out_predict_taken),
    .out_perceptron_sum (out_perceptron_sum),
    .out_trained        (out_trained)
  );

  assign m_tdata = {out_trained, out_perceptron_sum, out_predict_taken};

  // Hold off new words until the previous one has left the datapath
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while another is in flight");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // A prediction result that says taken never reports training
  a_predict_untrained: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> !m_tdata[15])
    else $error("predict result flagged as trained");

  // Update write never coincides with the group sums or the final sum
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_update && (cmd.do_final || cmd.calc_partial)))
    else $error("update and predict steps overlap");

endmodule
`default_nettype wire

// ===== test/perceptron_local_branch_predictor_unit_test.sv =====
// Self-checking testbench of the perceptron branch predictor with local history.
`default_nettype none

class branch_scoreboard;
  // predictor state
  logic signed [7:0] weights [256][62];
  logic signed [7:0] biases [256];
  logic [61:0] hist [256];
  int unsigned fill [256];
  logic signed [13:0] kept_sum;
  logic [12:0] threshold;
  // pending results: {trained, sum, predict_taken}
  logic [15:0] pending_words [$];
  int mismatches;

  function new();
    foreach (biases[e]) begin
      biases[e] = 0;
      hist[e] = '0;
      fill[e] = 0;
      foreach (weights[e][i]) weights[e][i] = 0;
    end
    kept_sum = 0;
    threshold = plbp_pkg::THR_RESET;
    mismatches = 0;
  endfunction

  function int slot(int e, int i);
    if (i + fill[e] < 62) return 0;
    return hist[e][i] ? 1 : -1;
  endfunction

  function logic signed [7:0] sat8(int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v[7:0];
  endfunction

  function void note_word(logic cmd, logic [47:0] pc, logic pred, logic act);
    int e;
    int acc;
    int t;
    int mag;
    logic do_train;
    e = int'(pc[11:4]);
    if (cmd == plbp_pkg::CMD_PREDICT) begin
      acc = biases[e];
      for (int i = 0; i < 62; i++) acc += weights[e][i] * slot(e, i);
      if (acc > 8191) acc = 8191;
      if (acc < -8192) acc = -8192;
      kept_sum = acc[13:0];
      pending_words.insert(pending_words.size(), {1'b0, kept_sum, kept_sum > 0});
    end else begin
      t = act ? 1 : -1;
      mag = kept_sum < 0 ? -kept_sum : kept_sum;
      do_train = (pred != act) || (mag <= threshold);
      if (do_train) begin
        biases[e] = sat8(biases[e] + t);
        for (int i = 0; i < 62; i++) weights[e][i] = sat8(weights[e][i] + t * slot(e, i));
      end
      hist[e] = {act, hist[e][61:1]};
      if (fill[e] < 62) fill[e]++;
      pending_words.insert(pending_words.size(), {do_train, kept_sum, 1'b0});
    end
  endfunction

  function void check_word(logic [15:0] got);
    logic [15:0] want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word %h", got);
      return;
    end
    want = pending_words.pop_front();
    if (got[0] !== want[0] || got[14:1] !== want[14:1] || got[15] !== want[15]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected taken=%0d sum=%0d trained=%0d, got taken=%0d sum=%0d trained=%0d",
                 want[0], $signed(want[14:1]), want[15], got[0], $signed(got[14:1]), got[15]);
    end
  endfunction
endclass

module perceptron_local_branch_predictor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic cfg_wr_en = 0;
  logic [12:0] cfg_wr_data = '0;

  branch_scoreboard board;
  int idle_pct = 30;          // sender idling percentage
  int sink_idle_pct = 30;     // receiver idling percentage
  bit hold_sink = 0;          // long receiver hold-off
  int quiet_cycles = 0;
  bit sim_done = 0;

  always #2 clk = ~clk;

  perceptron_local_branch_predictor_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Receiver: random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_word(m_tdata);
      m_tready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; note it at acceptance.
  task automatic send_word(logic cmd, logic [47:0] pc, logic pred, logic act);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {6'd0, act, pred, pc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_word(cmd, pc, pred, act);
  endtask

  task automatic pause_sender();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  // Wait for every expected word, then let the block settle.
  task automatic drain();
    pause_sender();
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic [12:0] value);
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.threshold = value;
  endtask

  // Entry pc with random stray high and low bits.
  function automatic logic [47:0] pc_for(int e);
    logic [47:0] pc;
    pc = 48'({$urandom, $urandom});
    pc[11:4] = e[7:0];
    return pc;
  endfunction

  // Well-formed branch: predict, then update with that prediction.
  task automatic branch_pair(int e, bit act);
    logic [47:0] pc;
    logic pred;
    pc = pc_for(e);
    send_word(plbp_pkg::CMD_PREDICT, pc, 0, 0);
    pred = board.kept_sum > 0;
    send_word(plbp_pkg::CMD_UPDATE, pc, pred, act);
  endtask

  initial begin
    int e;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: update before any predict, field extremes, and history fill.
    send_word(plbp_pkg::CMD_UPDATE, 48'h0, 0, 0);
    send_word(plbp_pkg::CMD_PREDICT, 48'hFFFF_FFFF_FFFF, 1, 1);
    send_word(plbp_pkg::CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 1, 1);
    send_word(plbp_pkg::CMD_PREDICT, 48'h0, 0, 0);
    send_word(plbp_pkg::CMD_UPDATE, 48'h0000_0000_0010, 1, 0);
    send_word(plbp_pkg::CMD_UPDATE, 48'h0000_0000_0010, 0, 1);
    send_word(plbp_pkg::CMD_PREDICT, 48'h0000_0000_0010, 0, 0);
    drain();
    write_threshold(13'h1FFF);
    for (int k = 0; k < 18; k++) send_word(plbp_pkg::CMD_UPDATE, 48'h30, 1, 1);
    drain();

    // Random phases at several threshold settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_threshold(13'd0);
        1: write_threshold(13'h1FFF);
        2: write_threshold(13'($urandom_range(8191)));
        default: write_threshold(13'd133);
      endcase
      idle_pct = (ph == 1) ? 0 : 30;
      sink_idle_pct = (ph == 1) ? 0 : 30;
      if (ph == 2) fork
        begin
          hold_sink = 1;
          repeat (300) @(posedge clk);
          hold_sink = 0;
        end
      join_none
      for (int k = 0; k < 120; k++) begin
        e = $urandom_range(99) < 80 ? $urandom_range(7) : $urandom_range(255);
        if ($urandom_range(99) < 85) begin
          // mostly biased branches so that weights build up
          branch_pair(e, 1'((e % 3 == 0) ? 1
                            : ($urandom_range(99) < 85 ? e[0] : $urandom_range(1))));
        end else begin
          send_word(1'($urandom_range(1)), 48'({$urandom, $urandom}),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
      drain();
    end

    sim_done = 1;
    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
